>>> rtl/normal_cdf_approximation_assert.svh
// Assertion macros shared by the normal CDF block.
`ifndef NORMAL_CDF_APPROXIMATION_ASSERT_SVH
`define NORMAL_CDF_APPROXIMATION_ASSERT_SVH

// Check cons in the same cycle as ante.
`define NCDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define NCDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ncdf_pkg.sv
// Constants, stage schedule and stage record for the normal CDF pipeline.
`timescale 1ns / 1ps
package ncdf_pkg;

    localparam logic [63:0] Q_ONE         = 64'h0000_0001_0000_0000;
    localparam logic [63:0] U_CAP         = 64'h0000_0006_0000_0000;
    localparam logic [63:0] INV_SQRT2_Q32 = 64'd3037000500;
    localparam logic [63:0] P_Q32         = 64'd1406993061;
    localparam longint      A1_Q32        = 64'sd1094484764;
    localparam longint      A2_Q32        = -64'sd1221904177;
    localparam longint      A3_Q32        = 64'sd6104925532;
    localparam longint      A4_Q32        = -64'sd6241240432;
    localparam longint      A5_Q32        = 64'sd4558701605;

    localparam int EXP_TERMS  = 12;
    localparam int DIV_BITS   = 4;

    localparam int DIV_FIRST  = 3;
    localparam int DIV_LAST   = 10;
    localparam int EXP_FIRST  = 3;
    localparam int EXP_LAST   = 26;
    localparam int SQ_FIRST   = 27;
    localparam int SQ_LAST    = 32;
    localparam int POLY_FIRST = 11;
    localparam int POLY_LAST  = 20;
    localparam int C_STAGE    = 33;
    localparam int NUM_STAGES = 34;

    typedef struct packed {
        logic        neg;
        logic        cap;
        logic [15:0] ax;
        logic [34:0] u;
        logic [33:0] denom;
        logic [33:0] rem;
        logic [31:0] quo;
        logic [35:0] hp;
        logic [31:0] r;
        logic [31:0] ep;
        logic [32:0] he;
        logic [32:0] c;
    } stage_t;

    function automatic logic [35:0] poly_coef(input int idx);
        logic [35:0] coef;
        case (idx)
            0:       coef = 36'(A4_Q32);
            1:       coef = 36'(A3_Q32);
            2:       coef = 36'(A2_Q32);
            3:       coef = 36'(A1_Q32);
            default: coef = 36'd0;
        endcase
        return coef;
    endfunction

endpackage

>>> rtl/ncdf_stage.sv
// Next-state logic of one pipeline stage of the normal CDF datapath.
`timescale 1ns / 1ps
module ncdf_stage #(
    parameter int STAGE         = 0,
    parameter int ARG_FRAC_BITS = 12
) (
    input  ncdf_pkg::stage_t prev,
    output ncdf_pkg::stage_t next
);

    localparam bit IN_EXP  = (STAGE >= ncdf_pkg::EXP_FIRST) && (STAGE <= ncdf_pkg::EXP_LAST);
    localparam bit IN_POLY = (STAGE >= ncdf_pkg::POLY_FIRST) && (STAGE <= ncdf_pkg::POLY_LAST);
    localparam bit IS_DIV  = (STAGE >= ncdf_pkg::DIV_FIRST) && (STAGE <= ncdf_pkg::DIV_LAST);
    localparam bit IS_SQ   = (STAGE >= ncdf_pkg::SQ_FIRST) && (STAGE <= ncdf_pkg::SQ_LAST);
    localparam bit IS_EXP_MUL  = IN_EXP && (((STAGE - ncdf_pkg::EXP_FIRST) % 2) == 0);
    localparam bit IS_EXP_DIV  = IN_EXP && (((STAGE - ncdf_pkg::EXP_FIRST) % 2) == 1);
    localparam bit IS_POLY_MUL = IN_POLY && (((STAGE - ncdf_pkg::POLY_FIRST) % 2) == 0);
    localparam bit IS_POLY_ADD = IN_POLY && (((STAGE - ncdf_pkg::POLY_FIRST) % 2) == 1);

    localparam int EXP_IDX  = IN_EXP ? (STAGE - ncdf_pkg::EXP_FIRST) / 2 : 0;
    localparam int EXP_K    = ncdf_pkg::EXP_TERMS - EXP_IDX;
    localparam int EXP_L    = $clog2(EXP_K);
    localparam logic [32:0] EXP_MAGIC =
        33'(((64'd1 << (32 + EXP_L)) + 64'(EXP_K) - 64'd1) / 64'(EXP_K));
    localparam int POLY_IDX = IN_POLY ? (STAGE - ncdf_pkg::POLY_FIRST) / 2 : 0;
    localparam logic [35:0] POLY_ADD = ncdf_pkg::poly_coef(POLY_IDX);

    logic [47:0] scale_prod;
    logic [47:0] u_wide;
    logic [65:0] pu_prod;
    logic [69:0] sq_prod;
    logic [64:0] ep_prod;
    logic [64:0] q_prod;
    logic [65:0] he_prod;
    logic [34:0] hp_mag;
    logic [66:0] pm_prod;
    logic [34:0] hp_pos;
    logic [67:0] c_prod;
    logic [35:0] c_wide;
    logic [34:0] rem_try;
    logic [33:0] rem_work;
    logic [31:0] quo_work;

    always_comb
    begin
        next       = prev;
        scale_prod = 48'(prev.ax) * 48'(ncdf_pkg::INV_SQRT2_Q32);
        u_wide     = scale_prod >> ARG_FRAC_BITS;
        pu_prod    = 66'(prev.u) * 66'(ncdf_pkg::P_Q32);
        sq_prod    = 70'(prev.u) * 70'(prev.u);
        ep_prod    = 65'(prev.r) * 65'(prev.he);
        q_prod     = 65'(prev.ep) * 65'(EXP_MAGIC);
        he_prod    = 66'(prev.he) * 66'(prev.he);
        hp_mag     = prev.hp[35] ? 35'(36'd0 - prev.hp) : prev.hp[34:0];
        pm_prod    = 67'(hp_mag) * 67'(prev.quo);
        hp_pos     = prev.hp[35] ? 35'd0 : prev.hp[34:0];
        c_prod     = 68'(hp_pos) * 68'(prev.he);
        c_wide     = c_prod[67:32];
        rem_try    = '0;
        rem_work   = prev.rem;
        quo_work   = prev.quo;
        for (int i = 0; i < ncdf_pkg::DIV_BITS; i++)
        begin
            rem_try = {rem_work, 1'b1};
            if (rem_try >= {1'b0, prev.denom})
            begin
                rem_work = 34'(rem_try - {1'b0, prev.denom});
                quo_work = {quo_work[30:0], 1'b1};
            end
            else
            begin
                rem_work = rem_try[33:0];
                quo_work = {quo_work[30:0], 1'b0};
            end
        end

        if (STAGE == 0)
        begin
            next.neg = prev.ax[15];
            next.ax  = prev.ax[15] ? 16'(~prev.ax + 16'd1) : prev.ax;
        end
        if (STAGE == 1)
        begin
            next.cap = (u_wide >= 48'(ncdf_pkg::U_CAP));
            next.u   = u_wide[34:0];
        end
        if (STAGE == 2)
        begin
            next.denom = 34'(ncdf_pkg::Q_ONE) + pu_prod[65:32];
            next.r     = sq_prod[69:38];
            next.rem   = 34'(ncdf_pkg::Q_ONE - 64'd1);
            next.quo   = '0;
            next.he    = 33'(ncdf_pkg::Q_ONE);
            next.hp    = 36'(ncdf_pkg::A5_Q32);
        end
        if (IS_DIV)
        begin
            next.rem = rem_work;
            next.quo = quo_work;
        end
        if (IS_EXP_MUL)
        begin
            next.ep = ep_prod[63:32];
        end
        if (IS_EXP_DIV)
        begin
            next.he = 33'(ncdf_pkg::Q_ONE) - 33'(q_prod >> (32 + EXP_L));
        end
        if (IS_SQ)
        begin
            next.he = he_prod[64:32];
        end
        if (IS_POLY_MUL)
        begin
            next.hp = prev.hp[35] ? (36'd0 - {1'b0, pm_prod[66:32]}) : {1'b0, pm_prod[66:32]};
        end
        if (IS_POLY_ADD)
        begin
            next.hp = prev.hp + POLY_ADD;
        end
        if (STAGE == ncdf_pkg::C_STAGE)
        begin
            if (prev.cap)
            begin
                next.c = '0;
            end
            else if (c_wide > 36'(ncdf_pkg::Q_ONE))
            begin
                next.c = 33'(ncdf_pkg::Q_ONE);
            end
            else
            begin
                next.c = c_wide[32:0];
            end
        end
    end

endmodule

>>> rtl/normal_cdf_approximation.sv
// Pipelined standard normal CDF, Abramowitz-Stegun 7.1.26, fixed point.
//
// Input channel: in_valid, in_stall, arg_value (signed, ARG_FRAC_BITS fraction bits).
// Output channel: out_valid, out_stall, probability (unsigned, OUT_BITS fraction bits,
// saturated at all ones).
// An item moves at a rising edge where valid is high and stall is low.
// Throughput: one item per cycle while the receiver does not stall. The 35 register
// stages, the first loaded at the accepting edge, are: input, scaling, denominator
// and square, 24 stages for the 12-term exponential series (product, then constant
// division by reciprocal) with 8 reciprocal stages at 4 quotient bits each and then
// 10 polynomial stages alongside, 6 squaring stages, the final product and the
// output rounding register.
// Each stage holds its item until the next stage is free, so bubbles close
// up; in_stall rises only when every stage and the output register are full
// and the receiver stalls.
// Reset clears all valid bits; no item is in flight afterwards.
`timescale 1ns / 1ps
module normal_cdf_approximation #(
    parameter int ARG_FRAC_BITS = 12,
    parameter int OUT_BITS      = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         arg_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_BITS-1:0] probability
);

    localparam int NS    = ncdf_pkg::NUM_STAGES;
    localparam int RES_W = 35 + OUT_BITS;
    localparam logic [OUT_BITS-1:0] MAXV = {OUT_BITS{1'b1}};

    ncdf_pkg::stage_t       in_item;
    ncdf_pkg::stage_t       pipe_reg  [NS];
    ncdf_pkg::stage_t       pipe_next [NS];
    logic [NS-1:0]          valid_reg;
    logic [NS:0]            en;
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    prob_reg;
    logic [OUT_BITS-1:0]    prob_next;
    logic [33:0]            num;
    logic [RES_W-1:0]       res;

    always_comb
    begin
        in_item    = '0;
        in_item.ax = arg_value;
    end

    assign en[NS]   = ~out_valid_reg | ~out_stall;
    assign in_stall = ~en[0];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            assign en[s] = ~valid_reg[s] | en[s+1];

            if (s == 0)
            begin : g_first
                ncdf_stage #(.STAGE(s), .ARG_FRAC_BITS(ARG_FRAC_BITS)) u_stage (
                    .prev (in_item),
                    .next (pipe_next[s])
                );

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        valid_reg[s] <= 1'b0;
                    end
                    else if (en[s])
                    begin
                        valid_reg[s] <= in_valid;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en[s] && in_valid)
                    begin
                        pipe_reg[s] <= pipe_next[s];
                    end
                end
            end
            else
            begin : g_rest
                ncdf_stage #(.STAGE(s), .ARG_FRAC_BITS(ARG_FRAC_BITS)) u_stage (
                    .prev (pipe_reg[s-1]),
                    .next (pipe_next[s])
                );

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        valid_reg[s] <= 1'b0;
                    end
                    else if (en[s])
                    begin
                        valid_reg[s] <= valid_reg[s-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en[s] && valid_reg[s-1])
                    begin
                        pipe_reg[s] <= pipe_next[s];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (pipe_reg[NS-1].neg)
        begin
            num = {1'b0, pipe_reg[NS-1].c};
        end
        else
        begin
            num = 34'h2_0000_0000 - {1'b0, pipe_reg[NS-1].c};
        end
        res = ((RES_W'(num) << OUT_BITS) + RES_W'(ncdf_pkg::Q_ONE)) >> 33;
        if (res > RES_W'(MAXV))
        begin
            prob_next = MAXV;
        end
        else
        begin
            prob_next = res[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en[NS])
        begin
            out_valid_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS] && valid_reg[NS-1])
        begin
            prob_reg <= prob_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign probability = prob_reg;

`include "normal_cdf_approximation_assert.svh"

    `NCDF_ASSERT_NOW(a_free_flow, !(out_valid && out_stall), !in_stall, "input stalled")
    `NCDF_ASSERT_NOW(a_full_stall, (&valid_reg) && out_valid && out_stall, in_stall, "full took")
    `NCDF_ASSERT_NEXT(a_no_phantom, !out_valid && !valid_reg[NS-1], !out_valid, "phantom result")

endmodule
